@@ src/bfha_pkg.sv @@
package bfha_pkg;

  // Widths fixed by the request and result fields
  localparam int FIELD_W  = 20;
  localparam int HDR_W    = 7;

  // Register reset values
  localparam logic [FIELD_W-1:0] CAP_RST = 20'd65536;
  localparam logic [HDR_W-1:0]   HDR_RST = 7'd32;

  // Register indexes on the configuration port
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_HEADER   = 1'b1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NULL = 2'd1,
    ST_OOM  = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  // What every cell of the chunk table does in one cycle
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ROT,
    OP_WRITE,
    OP_INSERT,
    OP_DELETE
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EXEC,
    S_FINISH
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [FIELD_W-1:0] req_size;
    logic [FIELD_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [FIELD_W-1:0] addr;
  } rsp_t;

endpackage

@@ src/best_fit_heap_allocator_unit.sv @@
// Best-fit heap allocator. Each request beat (allocate or free) yields one
// result beat. The chunk table lives in a ring of MAX_CHUNKS cells. A request
// rotates the whole ring once past the head cell to find the best fitting
// free chunk or the chunk whose data address matches. It then decides and
// applies the queued cell edits in turn, shifting cells to split, append or
// merge, and registers the result beat once the output is free. No new
// request is taken until the previous one has finished. Null requests
// (zero size, null address) skip the scan and go straight to the finish
// state. Once back in idle, a new request is taken while the previous result
// still waits at the output. Write the capacity and header size registers only
// while the block is idle.
module best_fit_heap_allocator_unit #(
  parameter int MAX_CHUNKS = 64,
  parameter int ADDR_BITS  = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bfha_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bfha_pkg::rsp_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [bfha_pkg::FIELD_W-1:0]  cfg_wdata_i
);

  localparam int N  = MAX_CHUNKS;
  localparam int AW = ADDR_BITS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  // wide enough for any unwrapped sum of an address, a size and a header
  localparam int W  = ((AW > bfha_pkg::FIELD_W) ? AW : bfha_pkg::FIELD_W) + 2;
  localparam int NOPS = 3;

  // ring of cells
  logic [AW-1:0] c_off   [N];
  logic [AW-1:0] c_bytes [N];
  logic          c_free  [N];

  bfha_pkg::cell_op_e cell_op;
  logic [IW-1:0]      cell_pos;
  logic [AW-1:0]      cell_off, cell_bytes;
  logic               cell_free;

  for (genvar gi = 0; gi < N; gi++) begin : g_cell
    bfha_cell #(
      .AW  (AW),
      .IW  (IW),
      .IDX (gi)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .pos_i       (cell_pos),
      .wr_off_i    (cell_off),
      .wr_bytes_i  (cell_bytes),
      .wr_free_i   (cell_free),
      .lft_off_i   (c_off[(gi + N - 1) % N]),
      .lft_bytes_i (c_bytes[(gi + N - 1) % N]),
      .lft_free_i  (c_free[(gi + N - 1) % N]),
      .rgt_off_i   (c_off[(gi + 1) % N]),
      .rgt_bytes_i (c_bytes[(gi + 1) % N]),
      .rgt_free_i  (c_free[(gi + 1) % N]),
      .off_o       (c_off[gi]),
      .bytes_o     (c_bytes[gi]),
      .free_o      (c_free[gi])
    );
  end

  // control state
  bfha_pkg::state_e state_q, state_d;
  logic [IW-1:0]    scan_k_q;
  logic [1:0]       exec_k_q;
  logic [CW-1:0]    cnt_q;
  logic [AW-1:0]    used_q;
  logic [bfha_pkg::FIELD_W-1:0] cap_q;
  logic [bfha_pkg::HDR_W-1:0]   hdr_q;
  logic             out_valid_q;

  // request and scan payload
  bfha_pkg::cmd_e               cmd_q;
  logic [bfha_pkg::FIELD_W-1:0] req_q, faddr_q;
  logic                         found_q;
  logic [IW-1:0]                pos_q;
  logic [AW-1:0]                cur_off_q, cur_bytes_q;
  logic [AW-1:0]                last_off_q, last_bytes_q;
  logic                         last_free_q;
  logic [AW-1:0]                prv_off_q, prv_bytes_q;
  logic                         prv_free_q;
  logic [AW-1:0]                nxt_bytes_q;
  logic                         nxt_free_q, nxt_vld_q, want_nxt_q;
  bfha_pkg::status_e            res_status_q;
  logic [AW-1:0]                res_addr_q;
  bfha_pkg::rsp_t               out_q;

  // queued table edits
  bfha_pkg::cell_op_e op_kind_q  [NOPS];
  logic [IW-1:0]      op_pos_q   [NOPS];
  logic [AW-1:0]      op_off_q   [NOPS];
  logic [AW-1:0]      op_bytes_q [NOPS];
  logic               op_free_q  [NOPS];

  logic in_fire, is_null, out_free;
  assign in_fire  = in_valid_i && in_ready_o;
  assign is_null  = (in_data_i.cmd == bfha_pkg::CMD_ALLOC) ? (in_data_i.req_size == '0)
                                                          : (in_data_i.free_addr == '0);
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------- scan
  logic          in_tab, fit, match, take;
  logic [AW-1:0] head_da;

  always_comb begin
    in_tab  = CW'(scan_k_q) < cnt_q;
    head_da = AW'(c_off[0] + AW'(hdr_q));
    fit     = c_free[0] && (W'(c_bytes[0]) >= W'(req_q)) &&
              (!found_q || (c_bytes[0] < cur_bytes_q));
    match   = !found_q && !c_free[0] && (W'(head_da) == W'(faddr_q));
    take    = in_tab && ((cmd_q == bfha_pkg::CMD_ALLOC) ? fit : match);
  end

  // ---------------------------------------------------------------- decide
  bfha_pkg::status_e  dec_status;
  logic [AW-1:0]      dec_addr;
  logic [CW-1:0]      dec_cnt;
  logic [AW-1:0]      dec_used;
  bfha_pkg::cell_op_e dec_kind  [NOPS];
  logic [IW-1:0]      dec_pos   [NOPS];
  logic [AW-1:0]      dec_off   [NOPS];
  logic [AW-1:0]      dec_bytes [NOPS];
  logic               dec_free  [NOPS];

  logic [W-1:0]  req_w, hdr_w, cur_w, used_w;
  logic          split, oom, mrg_nxt, mrg_prv;
  logic [AW-1:0] hit_bytes;
  logic [IW-1:0] pos_inc, pos_dec;

  always_comb begin
    req_w     = W'(req_q);
    hdr_w     = W'(hdr_q);
    cur_w     = W'(cur_bytes_q);
    used_w    = W'(used_q);
    pos_inc   = IW'({1'b0, pos_q} + 1'b1);
    pos_dec   = IW'({1'b0, pos_q} - 1'b1);
    split     = (cur_w > req_w + hdr_w) && (cnt_q < CW'(N));
    oom       = (cnt_q >= CW'(N)) || (used_w + req_w + hdr_w >= W'(cap_q));
    mrg_nxt   = nxt_vld_q && nxt_free_q;
    mrg_prv   = (pos_q != '0) && prv_free_q;
    hit_bytes = mrg_nxt ? AW'(cur_w + W'(nxt_bytes_q) + hdr_w) : cur_bytes_q;

    dec_status = bfha_pkg::ST_OK;
    dec_addr   = '0;
    dec_cnt    = cnt_q;
    dec_used   = used_q;
    for (int i = 0; i < NOPS; i++) begin
      dec_kind[i]  = bfha_pkg::OP_NOP;
      dec_pos[i]   = pos_q;
      dec_off[i]   = cur_off_q;
      dec_bytes[i] = cur_bytes_q;
      dec_free[i]  = 1'b0;
    end

    if (cmd_q == bfha_pkg::CMD_ALLOC) begin
      if (found_q) begin
        dec_addr = AW'(W'(cur_off_q) + hdr_w);
        if (split) begin
          // remainder becomes a free chunk just after the granted one
          dec_kind[0]  = bfha_pkg::OP_INSERT;
          dec_pos[0]   = pos_inc;
          dec_off[0]   = AW'(W'(cur_off_q) + hdr_w + req_w);
          dec_bytes[0] = AW'(cur_w - req_w - hdr_w);
          dec_free[0]  = 1'b1;
          dec_kind[1]  = bfha_pkg::OP_WRITE;
          dec_bytes[1] = AW'(req_w);
          dec_cnt      = CW'(cnt_q + 1'b1);
        end else begin
          dec_kind[0]  = bfha_pkg::OP_WRITE;
        end
      end else if (oom) begin
        dec_status = bfha_pkg::ST_OOM;
      end else begin
        // append at the end of the used area
        dec_kind[0]  = bfha_pkg::OP_WRITE;
        dec_pos[0]   = IW'(cnt_q);
        dec_off[0]   = used_q;
        dec_bytes[0] = AW'(req_w);
        dec_cnt      = CW'(cnt_q + 1'b1);
        dec_used     = AW'(used_w + hdr_w + req_w);
        dec_addr     = AW'(used_w + hdr_w);
      end
    end else begin
      if (!found_q) begin
        dec_status = bfha_pkg::ST_BAD;
      end else if (mrg_prv) begin
        // previous chunk absorbs this one (and the next one if free)
        dec_kind[0]  = bfha_pkg::OP_WRITE;
        dec_pos[0]   = pos_dec;
        dec_off[0]   = prv_off_q;
        dec_bytes[0] = AW'(W'(prv_bytes_q) + W'(hit_bytes) + hdr_w);
        dec_free[0]  = 1'b1;
        if (mrg_nxt) begin
          dec_kind[1] = bfha_pkg::OP_DELETE;
          dec_pos[1]  = pos_inc;
        end
        dec_kind[2] = bfha_pkg::OP_DELETE;
        dec_cnt     = CW'(cnt_q - 1'b1 - CW'(mrg_nxt));
      end else begin
        dec_kind[0]  = bfha_pkg::OP_WRITE;
        dec_bytes[0] = hit_bytes;
        dec_free[0]  = 1'b1;
        if (mrg_nxt) begin
          dec_kind[1] = bfha_pkg::OP_DELETE;
          dec_pos[1]  = pos_inc;
          dec_cnt     = CW'(cnt_q - 1'b1);
        end
      end
    end
  end

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfha_pkg::S_IDLE:   if (in_fire) state_d = is_null ? bfha_pkg::S_FINISH
                                                         : bfha_pkg::S_SCAN;
      bfha_pkg::S_SCAN:   if (scan_k_q == IW'(N - 1)) state_d = bfha_pkg::S_DECIDE;
      bfha_pkg::S_DECIDE: state_d = bfha_pkg::S_EXEC;
      bfha_pkg::S_EXEC:   if (exec_k_q == 2'(NOPS - 1)) state_d = bfha_pkg::S_FINISH;
      bfha_pkg::S_FINISH: if (out_free) state_d = bfha_pkg::S_IDLE;
      default:            state_d = bfha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == bfha_pkg::S_IDLE);
    cell_op    = bfha_pkg::OP_NOP;
    cell_pos   = op_pos_q[0];
    cell_off   = op_off_q[0];
    cell_bytes = op_bytes_q[0];
    cell_free  = op_free_q[0];
    unique case (state_q)
      bfha_pkg::S_SCAN: cell_op = bfha_pkg::OP_ROT;
      bfha_pkg::S_EXEC: cell_op = op_kind_q[0];
      default:          cell_op = bfha_pkg::OP_NOP;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfha_pkg::S_IDLE;
      scan_k_q    <= '0;
      exec_k_q    <= '0;
      cnt_q       <= '0;
      used_q      <= '0;
      cap_q       <= bfha_pkg::CAP_RST;
      hdr_q       <= bfha_pkg::HDR_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == bfha_pkg::CFG_CAPACITY) cap_q <= cfg_wdata_i;
        else                                     hdr_q <= cfg_wdata_i[bfha_pkg::HDR_W-1:0];
      end
      if (state_q == bfha_pkg::S_SCAN) begin
        scan_k_q <= (scan_k_q == IW'(N - 1)) ? '0 : IW'(scan_k_q + 1'b1);
      end
      if (state_q == bfha_pkg::S_EXEC) begin
        exec_k_q <= (exec_k_q == 2'(NOPS - 1)) ? '0 : 2'(exec_k_q + 1'b1);
      end
      if (state_q == bfha_pkg::S_DECIDE) begin
        cnt_q  <= dec_cnt;
        used_q <= dec_used;
      end
      if (state_q == bfha_pkg::S_FINISH && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)                           out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q        <= in_data_i.cmd;
      req_q        <= in_data_i.req_size;
      faddr_q      <= in_data_i.free_addr;
      found_q      <= 1'b0;
      want_nxt_q   <= 1'b0;
      nxt_vld_q    <= 1'b0;
      res_status_q <= bfha_pkg::ST_NULL;
      res_addr_q   <= '0;
    end
    if (state_q == bfha_pkg::S_SCAN) begin
      // hold the entry seen one step back for the previous-neighbour merge
      last_off_q   <= c_off[0];
      last_bytes_q <= c_bytes[0];
      last_free_q  <= c_free[0];
      if (want_nxt_q && in_tab) begin
        nxt_bytes_q <= c_bytes[0];
        nxt_free_q  <= c_free[0];
        nxt_vld_q   <= 1'b1;
      end
      // a freed chunk needs its next neighbour, seen on the following step
      want_nxt_q <= take && (cmd_q == bfha_pkg::CMD_FREE);
      if (take) begin
        found_q     <= 1'b1;
        pos_q       <= scan_k_q;
        cur_off_q   <= c_off[0];
        cur_bytes_q <= c_bytes[0];
        prv_off_q   <= last_off_q;
        prv_bytes_q <= last_bytes_q;
        prv_free_q  <= last_free_q;
      end
    end
    if (state_q == bfha_pkg::S_DECIDE) begin
      res_status_q <= dec_status;
      res_addr_q   <= dec_addr;
      for (int i = 0; i < NOPS; i++) begin
        op_kind_q[i]  <= dec_kind[i];
        op_pos_q[i]   <= dec_pos[i];
        op_off_q[i]   <= dec_off[i];
        op_bytes_q[i] <= dec_bytes[i];
        op_free_q[i]  <= dec_free[i];
      end
    end else if (state_q == bfha_pkg::S_EXEC) begin
      // advance the edit queue by one
      for (int i = 0; i < NOPS - 1; i++) begin
        op_kind_q[i]  <= op_kind_q[i+1];
        op_pos_q[i]   <= op_pos_q[i+1];
        op_off_q[i]   <= op_off_q[i+1];
        op_bytes_q[i] <= op_bytes_q[i+1];
        op_free_q[i]  <= op_free_q[i+1];
      end
      op_kind_q[NOPS-1] <= bfha_pkg::OP_NOP;
    end
    if (state_q == bfha_pkg::S_FINISH && out_free) begin
      out_q.status <= res_status_q;
      out_q.addr   <= bfha_pkg::FIELD_W'(res_addr_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(N))
    else $error("chunk count beyond table depth");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == bfha_pkg::S_SCAN || state_q == bfha_pkg::S_FINISH))
    else $error("accepted beat did not start work");

  a_addr_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != bfha_pkg::ST_OK) |-> out_data_o.addr == '0)
    else $error("non-zero address on failed request");

  a_scan_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfha_pkg::S_IDLE |-> (scan_k_q == '0 && exec_k_q == '0))
    else $error("scan or edit counter left running");
`endif

endmodule

@@ src/bfha_cell.sv @@
module bfha_cell #(
  parameter int AW  = 20,
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                 clk_i,
  input  bfha_pkg::cell_op_e   op_i,
  input  logic [IW-1:0]        pos_i,
  input  logic [AW-1:0]        wr_off_i,
  input  logic [AW-1:0]        wr_bytes_i,
  input  logic                 wr_free_i,
  input  logic [AW-1:0]        lft_off_i,
  input  logic [AW-1:0]        lft_bytes_i,
  input  logic                 lft_free_i,
  input  logic [AW-1:0]        rgt_off_i,
  input  logic [AW-1:0]        rgt_bytes_i,
  input  logic                 rgt_free_i,
  output logic [AW-1:0]        off_o,
  output logic [AW-1:0]        bytes_o,
  output logic                 free_o
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [AW-1:0] off_q, off_d;
  logic [AW-1:0] bytes_q, bytes_d;
  logic          free_q, free_d;

  always_comb begin
    off_d   = off_q;
    bytes_d = bytes_q;
    free_d  = free_q;
    case (op_i)
      bfha_pkg::OP_ROT: begin
        off_d   = rgt_off_i;
        bytes_d = rgt_bytes_i;
        free_d  = rgt_free_i;
      end
      bfha_pkg::OP_WRITE: begin
        if (MyIdx == pos_i) begin
          off_d   = wr_off_i;
          bytes_d = wr_bytes_i;
          free_d  = wr_free_i;
        end
      end
      bfha_pkg::OP_INSERT: begin
        // open a gap at pos: move up from the left neighbour
        if (MyIdx > pos_i) begin
          off_d   = lft_off_i;
          bytes_d = lft_bytes_i;
          free_d  = lft_free_i;
        end else if (MyIdx == pos_i) begin
          off_d   = wr_off_i;
          bytes_d = wr_bytes_i;
          free_d  = wr_free_i;
        end
      end
      bfha_pkg::OP_DELETE: begin
        // close the gap at pos: pull down from the right neighbour
        if (MyIdx >= pos_i) begin
          off_d   = rgt_off_i;
          bytes_d = rgt_bytes_i;
          free_d  = rgt_free_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    off_q   <= off_d;
    bytes_q <= bytes_d;
    free_q  <= free_d;
  end

  assign off_o   = off_q;
  assign bytes_o = bytes_q;
  assign free_o  = free_q;

endmodule
